FILE: src/ott_pkg.sv
// Shared types and constants of the one-shot timer table.
package ott_pkg;

    localparam int SLOT_COUNT = 10;
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int TICK_W     = 32;
    localparam int DELAY_W    = 24;
    localparam int HANDLER_W  = 4;
    localparam int ACTION_W   = 16;
    localparam int WHEEL_W    = 8;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_ARM  = 1'b1;
    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_FIRE = 1'b1;

    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [SLOT_COUNT-1:0] t_mask;
    typedef logic [TICK_W-1:0]     t_tick;

    typedef struct packed {
        logic                 mode;
        logic [DELAY_W-1:0]   delay_ms;
        logic [HANDLER_W-1:0] handler_id;
        logic [ACTION_W-1:0]  action_id;
        logic [WHEEL_W-1:0]   wheel_id;
    } t_req;

    typedef struct packed {
        logic                 kind;
        logic                 accepted;
        logic [HANDLER_W-1:0] fired_handler;
        logic [ACTION_W-1:0]  fired_action;
        logic [WHEEL_W-1:0]   fired_wheel;
        logic                 last;
    } t_res;

    typedef struct packed {
        logic [HANDLER_W-1:0] handler;
        logic [ACTION_W-1:0]  action;
        logic [WHEEL_W-1:0]   wheel;
    } t_slot_data;

    // controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic load_in;
        logic arm_do;
        logic mark_do;
        logic scan_rd;
        logic emit_do;
        logic idx_inc;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_valid;
        logic in_mode;
        logic out_free;
        logic mask_empty;
        logic mask_hit;
    } t_stat;

endpackage

FILE: src/ott_if.sv
// Request and result channel interfaces of the timer table.
interface ott_req_if;
    import ott_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ott_res_if;
    import ott_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/ott_ctrl.sv
// Controller state machine of the timer table: sequences arm and tick requests.
module ott_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ott_pkg::t_stat i_stat,
    output ott_pkg::t_cmd  o_cmd
);
    import ott_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ARM,
        S_MARK,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = (i_stat.in_mode == MODE_ARM) ? S_ARM : S_MARK;
                end
            end
            S_ARM: begin
                if (i_stat.out_free) begin
                    o_cmd.arm_do = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_MARK: begin
                o_cmd.mark_do = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                priority if (i_stat.mask_empty) begin
                    n_state = S_IDLE;
                end else if (i_stat.mask_hit) begin
                    o_cmd.scan_rd = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_do = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_SCAN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: src/ott_dp.sv
// Datapath of the timer table: counter, deadlines, slot memory, result register.
module ott_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ott_pkg::t_cmd  i_cmd,
    output ott_pkg::t_stat o_stat,
    ott_req_if.sink        i_req_ch,
    ott_res_if.source      o_res_ch
);
    import ott_pkg::*;

    t_tick      r_tick;
    t_tick      r_deadline [SLOT_COUNT];
    t_slot_data r_mem      [SLOT_COUNT];
    t_slot_data r_rd;
    t_req       r_in;
    t_mask      r_mask;
    t_idx       r_idx;
    logic       r_last;
    logic       r_out_valid;
    t_res       r_out;

    t_tick sum;
    t_idx  free_idx;
    logic  free_found;
    t_mask idx_bit;
    logic  idx_in_range;

    assign sum = r_tick + TICK_W'(r_in.delay_ms);

    // lowest-numbered free slot; descending loop so the lowest index wins
    always_comb begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (r_deadline[i] == '0) begin
                free_idx   = IDX_W'(i);
                free_found = 1'b1;
            end
        end
    end

    assign idx_bit      = t_mask'(1) << r_idx;
    assign idx_in_range = {1'b0, r_idx} < (IDX_W + 1)'(SLOT_COUNT);

    assign i_req_ch.ready    = i_cmd.in_ready;
    assign o_res_ch.valid    = r_out_valid;
    assign o_res_ch.data     = r_out;

    assign o_stat.in_valid   = i_req_ch.valid;
    assign o_stat.in_mode    = i_req_ch.data.mode;
    assign o_stat.out_free   = !r_out_valid || o_res_ch.ready;
    assign o_stat.mask_empty = (r_mask == '0);
    assign o_stat.mask_hit   = idx_in_range && ((r_mask & idx_bit) != '0);

    // control state: counter, deadlines, scan mask and index, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_mask      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_deadline[i] <= '0;
            end
        end else begin
            if (i_cmd.arm_do && free_found) begin
                r_deadline[free_idx] <= sum;
            end
            if (i_cmd.mark_do) begin
                // latch the expired set and free those slots now
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    r_mask[i] <= (r_deadline[i] != '0) && (r_deadline[i] <= r_tick);
                    if ((r_deadline[i] != '0) && (r_deadline[i] <= r_tick)) begin
                        r_deadline[i] <= '0;
                    end
                end
                r_tick <= r_tick + 1'b1;
                r_idx  <= '0;
            end
            if (i_cmd.scan_rd) begin
                r_mask <= r_mask & ~idx_bit;
            end
            if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.arm_do || i_cmd.emit_do) begin
                r_out_valid <= 1'b1;
            end else if (o_res_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_req_ch.data;
        end
        if (i_cmd.scan_rd) begin
            r_last <= ((r_mask & ~idx_bit) == '0);
        end
        if (i_cmd.arm_do) begin
            r_out.kind          <= KIND_ACK;
            r_out.accepted      <= free_found;
            r_out.fired_handler <= '0;
            r_out.fired_action  <= '0;
            r_out.fired_wheel   <= '0;
            r_out.last          <= 1'b1;
        end else if (i_cmd.emit_do) begin
            r_out.kind          <= KIND_FIRE;
            r_out.accepted      <= 1'b0;
            r_out.fired_handler <= r_rd.handler;
            r_out.fired_action  <= r_rd.action;
            r_out.fired_wheel   <= r_rd.wheel;
            r_out.last          <= r_last;
        end
    end

    // slot data memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.arm_do && free_found) begin
            r_mem[free_idx] <= '{handler: r_in.handler_id,
                                 action:  r_in.action_id,
                                 wheel:   r_in.wheel_id};
        end
        if (i_cmd.scan_rd) begin
            r_rd <= r_mem[r_idx];
        end
    end

endmodule

FILE: src/one_shot_timer_table_core.sv
// Top level of the one-shot timer table.
// One request at a time. An arm request passes through the arm state and returns
// one acknowledgment. A tick request latches the expired set in the mark state and
// then scans the slots up to the highest slot index that expires on this tick;
// with no expiry the scan ends at once. The scan walks the slots one index per
// cycle while no expiry is found, takes the emit state per expiry after the
// registered read of the slot data memory, and ends when it sees the expired set
// empty. Result stalls hold the arm and emit states only while the result
// register is still occupied. No clearing pass is run after reset.
module one_shot_timer_table_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ott_req_if.sink   i_req_ch,
    ott_res_if.source o_res_ch
);
    import ott_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ott_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    ott_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .i_req_ch (i_req_ch),
        .o_res_ch (o_res_ch)
    );

endmodule

FILE: src/ott_checker.sv
// Port-level checker of the timer table and its bind to the top level.
module ott_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_req_valid,
    input logic          i_req_ready,
    input logic          i_res_valid,
    input logic          i_res_ready,
    input ott_pkg::t_res i_res_data
);
    import ott_pkg::*;

    // result stays offered until taken
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped before taken");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result offered right after reset");

    // one request at a time: busy right after an accepted request
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while busy");

    a_ack_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_data.kind == KIND_ACK) |->
            i_res_data.last && (i_res_data.fired_handler == '0) &&
            (i_res_data.fired_action == '0) && (i_res_data.fired_wheel == '0))
        else $error("malformed acknowledgment");

    a_fire_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_data.kind == KIND_FIRE) |-> !i_res_data.accepted)
        else $error("expiry with accepted set");

endmodule

bind one_shot_timer_table_core ott_checker u_ott_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_ch.valid),
    .i_req_ready (i_req_ch.ready),
    .i_res_valid (o_res_ch.valid),
    .i_res_ready (o_res_ch.ready),
    .i_res_data  (o_res_ch.data)
);
